### src/bbrm_pkg.sv
// ----------------------------------------------------------------------------
// bbrm_pkg
// Shared types and constants for the bip buffer region manager.
// ----------------------------------------------------------------------------
package bbrm_pkg;

   // fixed field widths
   localparam int CMD_W    = 3;
   localparam int AMOUNT_W = 17;
   localparam int SIZE_W   = 17;

   // buffer_size after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_COMMIT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CONSUME = 3'd4;

   // status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   // one request word
   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [AMOUNT_W-1:0] amount;
   } bbrm_req_type;

endpackage

### src/bbrm_req_if.sv
// ----------------------------------------------------------------------------
// bbrm_req_if
// Request channel: valid/ready handshake carrying command and amount.
// ----------------------------------------------------------------------------
interface bbrm_req_if;
   import bbrm_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [AMOUNT_W-1:0] amount;

   modport source (output valid, command, amount, input ready);
   modport sink   (input valid, command, amount, output ready);

endinterface

### src/bbrm_rsp_if.sv
// ----------------------------------------------------------------------------
// bbrm_rsp_if
// Response channel: valid/ready handshake carrying status and two spans.
// ----------------------------------------------------------------------------
interface bbrm_rsp_if #(
   parameter int OFFSET_BITS = 16
);
   import bbrm_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   status;
   logic [OFFSET_BITS-1:0] first_offset;
   logic [AMOUNT_W-1:0]    first_length;
   logic [OFFSET_BITS-1:0] second_offset;
   logic [AMOUNT_W-1:0]    second_length;

   modport source (output valid, status, first_offset, first_length,
                   second_offset, second_length, input ready);
   modport sink   (input valid, status, first_offset, first_length,
                   second_offset, second_length, output ready);

endinterface

### src/bbrm_in_stage.sv
// ----------------------------------------------------------------------------
// bbrm_in_stage
// Input register: holds one request word until the engine takes it.
// ----------------------------------------------------------------------------
module bbrm_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   bbrm_req_if.sink              req_chan,
   input  logic                  out_free,
   output logic                  fire,
   output bbrm_pkg::bbrm_req_type req_word
);
   import bbrm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   bbrm_req_type word_ff;
   logic         accept;

   // word moves on when the output register can take its result
   assign fire           = valid_ff && out_free;
   assign req_chan.ready = !valid_ff || fire;
   assign accept         = req_chan.valid && req_chan.ready;
   assign req_word       = word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         word_ff.command <= req_chan.command;
         word_ff.amount  <= req_chan.amount;
      end
   end

endmodule

### src/bbrm_engine.sv
// ----------------------------------------------------------------------------
// bbrm_engine
// Region state, buffer_size register and the per-command update logic.
// ----------------------------------------------------------------------------
module bbrm_engine #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [bbrm_pkg::SIZE_W-1:0] csr_wr_data,
   input  logic                        fire,
   input  bbrm_pkg::bbrm_req_type      req_word,
   output logic                        res_status,
   output logic [OFFSET_BITS-1:0]      res_first_offset,
   output logic [bbrm_pkg::AMOUNT_W-1:0] res_first_length,
   output logic [OFFSET_BITS-1:0]      res_second_offset,
   output logic [bbrm_pkg::AMOUNT_W-1:0] res_second_length
);
   import bbrm_pkg::*;

   // offsets reach 2^OFFSET_BITS, sums need one more bit
   localparam int STATE_W = OFFSET_BITS + 1;
   localparam int SUM_W   = ((STATE_W > AMOUNT_W) ? STATE_W : AMOUNT_W) + 1;
   localparam logic [SUM_W-1:0] CAP = SUM_W'(1) << OFFSET_BITS;

   logic [STATE_W-1:0]  a_start_ff, a_end_ff, b_start_ff, b_end_ff;
   logic [STATE_W-1:0]  a_start_in, a_end_in, b_start_in, b_end_in;
   logic                read_sel_ff, write_sel_ff, read_sel_in, write_sel_in;
   logic [AMOUNT_W-1:0] reserved_ff, reserved_in;
   logic [SIZE_W-1:0]   size_ff;

   logic [SUM_W-1:0] eff_size, amt;
   logic [SUM_W-1:0] start_rd, end_rd, start_wr, end_wr;
   logic [SUM_W-1:0] len_rd, len_wr, end_plus, rd_adv, rest, wr_adv;
   logic             same_sel, take;

   // operand selection
   assign eff_size = (SUM_W'(size_ff) > CAP) ? CAP : SUM_W'(size_ff);
   assign amt      = SUM_W'(req_word.amount);
   assign start_rd = SUM_W'(read_sel_ff  ? b_start_ff : a_start_ff);
   assign end_rd   = SUM_W'(read_sel_ff  ? b_end_ff   : a_end_ff);
   assign start_wr = SUM_W'(write_sel_ff ? b_start_ff : a_start_ff);
   assign end_wr   = SUM_W'(write_sel_ff ? b_end_ff   : a_end_ff);
   assign same_sel = read_sel_ff == write_sel_ff;
   assign take     = req_word.command == CMD_CONSUME;

   // region lengths and advanced offsets
   assign len_rd   = (end_rd > start_rd) ? end_rd - start_rd : '0;
   assign len_wr   = (end_wr > start_wr) ? end_wr - start_wr : '0;
   assign end_plus = end_wr + amt;
   assign rd_adv   = start_rd + amt;
   assign rest     = amt - len_rd;
   assign wr_adv   = start_wr + rest;

   // command decode and next state
   always_comb begin
      a_start_in        = a_start_ff;
      a_end_in          = a_end_ff;
      b_start_in        = b_start_ff;
      b_end_in          = b_end_ff;
      read_sel_in       = read_sel_ff;
      write_sel_in      = write_sel_ff;
      reserved_in       = reserved_ff;
      res_status        = STATUS_REFUSED;
      res_first_offset  = '0;
      res_first_length  = '0;
      res_second_offset = '0;
      res_second_length = '0;

      unique case (req_word.command) inside
         CMD_CLEAR: begin
            a_start_in  = '0;
            a_end_in    = '0;
            b_start_in  = '0;
            b_end_in    = '0;
            reserved_in = '0;
            res_status  = STATUS_OK;
         end
         CMD_RESERVE: begin
            if (same_sel) begin
               if (end_plus <= eff_size) begin
                  reserved_in      = req_word.amount;
                  res_status       = STATUS_OK;
                  res_first_offset = end_wr[OFFSET_BITS-1:0];
                  res_first_length = req_word.amount;
               end else if (start_rd >= amt) begin
                  // switch writing to the other region, emptied
                  write_sel_in = !write_sel_ff;
                  if (write_sel_ff) begin
                     a_start_in = '0;
                     a_end_in   = '0;
                  end else begin
                     b_start_in = '0;
                     b_end_in   = '0;
                  end
                  reserved_in      = req_word.amount;
                  res_status       = STATUS_OK;
                  res_first_length = req_word.amount;
               end
            end else if (end_plus <= start_rd) begin
               reserved_in      = req_word.amount;
               res_status       = STATUS_OK;
               res_first_offset = end_wr[OFFSET_BITS-1:0];
               res_first_length = req_word.amount;
            end
         end
         CMD_COMMIT: begin
            if (amt <= SUM_W'(reserved_ff)) begin
               res_status       = STATUS_OK;
               res_first_offset = end_wr[OFFSET_BITS-1:0];
               res_first_length = req_word.amount;
               reserved_in      = '0;
               if (write_sel_ff) begin
                  b_end_in = end_plus[STATE_W-1:0];
               end else begin
                  a_end_in = end_plus[STATE_W-1:0];
               end
            end
         end
         CMD_PEEK, CMD_CONSUME: begin
            if (amt <= len_rd) begin
               res_status       = STATUS_OK;
               res_first_offset = start_rd[OFFSET_BITS-1:0];
               res_first_length = req_word.amount;
               if (take) begin
                  // advance read start, drained region goes to [0,0)
                  if (read_sel_ff) begin
                     b_start_in = (rd_adv == end_rd) ? '0 : rd_adv[STATE_W-1:0];
                     b_end_in   = (rd_adv == end_rd) ? '0 : b_end_ff;
                  end else begin
                     a_start_in = (rd_adv == end_rd) ? '0 : rd_adv[STATE_W-1:0];
                     a_end_in   = (rd_adv == end_rd) ? '0 : a_end_ff;
                  end
               end
            end else if (!same_sel && (amt <= len_rd + len_wr)) begin
               // cross-region read: rest of read region, then write region
               res_status        = STATUS_OK;
               res_first_offset  = start_rd[OFFSET_BITS-1:0];
               res_first_length  = len_rd[AMOUNT_W-1:0];
               res_second_offset = start_wr[OFFSET_BITS-1:0];
               res_second_length = rest[AMOUNT_W-1:0];
               if (take) begin
                  read_sel_in = write_sel_ff;
                  if (read_sel_ff) begin
                     b_start_in = '0;
                     b_end_in   = '0;
                     a_start_in = (wr_adv == end_wr) ? '0 : wr_adv[STATE_W-1:0];
                     a_end_in   = (wr_adv == end_wr) ? '0 : a_end_ff;
                  end else begin
                     a_start_in = '0;
                     a_end_in   = '0;
                     b_start_in = (wr_adv == end_wr) ? '0 : wr_adv[STATE_W-1:0];
                     b_end_in   = (wr_adv == end_wr) ? '0 : b_end_ff;
                  end
               end
            end
         end
         default: begin
            // unknown command: refused, state held
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_start_ff   <= '0;
         a_end_ff     <= '0;
         b_start_ff   <= '0;
         b_end_ff     <= '0;
         read_sel_ff  <= 1'b0;
         write_sel_ff <= 1'b0;
         reserved_ff  <= '0;
      end else if (fire) begin
         a_start_ff   <= a_start_in;
         a_end_ff     <= a_end_in;
         b_start_ff   <= b_start_in;
         b_end_ff     <= b_end_in;
         read_sel_ff  <= read_sel_in;
         write_sel_ff <= write_sel_in;
         reserved_ff  <= reserved_in;
      end
   end

   // buffer_size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // regions never invert
   a_region_order: assert property (@(posedge clock) disable iff (reset)
      (a_start_ff <= a_end_ff) && (b_start_ff <= b_end_ff))
      else $error("region start beyond region end");

   // region ends stay inside the addressable store
   a_region_bound: assert property (@(posedge clock) disable iff (reset)
      (SUM_W'(a_end_ff) <= CAP) && (SUM_W'(b_end_ff) <= CAP))
      else $error("region end beyond store");

   // a granted commit releases the reservation
   a_commit_release: assert property (@(posedge clock) disable iff (reset)
      fire && (req_word.command == CMD_COMMIT) && (amt <= SUM_W'(reserved_ff))
      |=> reserved_ff == '0)
      else $error("reservation kept after commit");

   // unknown commands leave the regions alone
   a_unknown_hold: assert property (@(posedge clock) disable iff (reset)
      fire && (req_word.command > CMD_CONSUME)
      |=> $stable(a_start_ff) && $stable(a_end_ff) && $stable(b_start_ff)
          && $stable(b_end_ff) && $stable(read_sel_ff)
          && $stable(write_sel_ff) && $stable(reserved_ff))
      else $error("state changed on unknown command");

endmodule

### src/bbrm_out_stage.sv
// ----------------------------------------------------------------------------
// bbrm_out_stage
// Output register: holds one response word until the sink takes it.
// ----------------------------------------------------------------------------
module bbrm_out_stage #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic                          res_status,
   input  logic [OFFSET_BITS-1:0]        res_first_offset,
   input  logic [bbrm_pkg::AMOUNT_W-1:0] res_first_length,
   input  logic [OFFSET_BITS-1:0]        res_second_offset,
   input  logic [bbrm_pkg::AMOUNT_W-1:0] res_second_length,
   output logic                          out_free,
   bbrm_rsp_if.source                    rsp_chan
);
   import bbrm_pkg::*;

   logic                   valid_ff;
   logic                   valid_in;
   logic                   status_ff;
   logic [OFFSET_BITS-1:0] first_offset_ff, second_offset_ff;
   logic [AMOUNT_W-1:0]    first_length_ff, second_length_ff;

   // room for a new word when empty or being drained
   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff        <= res_status;
         first_offset_ff  <= res_first_offset;
         first_length_ff  <= res_first_length;
         second_offset_ff <= res_second_offset;
         second_length_ff <= res_second_length;
      end
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.first_offset  = first_offset_ff;
   assign rsp_chan.first_length  = first_length_ff;
   assign rsp_chan.second_offset = second_offset_ff;
   assign rsp_chan.second_length = second_length_ff;

endmodule

### src/bip_buffer_region_manager_core.sv
// Path: a request word is held in the input register, its response in the output register.
// Throughput: one word per cycle unless the sink stalls; the command logic is a
// single registered pass over the region offsets, limited by the engine's compare/add path.
// Reset: regions empty, both selectors on region a, no reservation,
// buffer_size 4096; no clearing pass, a request is taken right after reset.
// ----------------------------------------------------------------------------
// bip_buffer_region_manager_core
// Offset manager for a bipartite circular buffer: input register, command
// engine with region state, output register.
// ----------------------------------------------------------------------------
module bip_buffer_region_manager_core #(
   parameter int OFFSET_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [bbrm_pkg::SIZE_W-1:0] csr_wr_data,
   bbrm_req_if.sink                    req_chan,
   bbrm_rsp_if.source                  rsp_chan
);
   import bbrm_pkg::*;

   logic                   fire;
   logic                   out_free;
   bbrm_req_type           req_word;
   logic                   res_status;
   logic [OFFSET_BITS-1:0] res_first_offset, res_second_offset;
   logic [AMOUNT_W-1:0]    res_first_length, res_second_length;

   bbrm_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .out_free (out_free),
      .fire     (fire),
      .req_word (req_word)
   );

   bbrm_engine #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .fire              (fire),
      .req_word          (req_word),
      .res_status        (res_status),
      .res_first_offset  (res_first_offset),
      .res_first_length  (res_first_length),
      .res_second_offset (res_second_offset),
      .res_second_length (res_second_length)
   );

   bbrm_out_stage #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_out_stage (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .res_status        (res_status),
      .res_first_offset  (res_first_offset),
      .res_first_length  (res_first_length),
      .res_second_offset (res_second_offset),
      .res_second_length (res_second_length),
      .out_free          (out_free),
      .rsp_chan          (rsp_chan)
   );

endmodule

### bench/tb_bip_buffer_region_manager_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bip_buffer_region_manager_core
// Self-checking bench for the bip buffer region manager. A scoreboard keeps
// its own copy of the two regions, the selectors and the reservation, works
// out the response to every accepted request word and compares each response
// word field by field, in order. A directed opener walks region switching,
// cross-region reads and refusals. It is followed by random request streams
// shaped from the tracked state, run under several buffer sizes with random
// idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_bip_buffer_region_manager_core;
   import bbrm_pkg::*;

   localparam int OB           = 16;
   localparam int PHASES       = 8;
   localparam int PHASE_WORDS  = 219;
   localparam int CALM_WORDS   = 200;
   localparam int STUCK_LIMIT  = 3000;
   localparam int PRINT_LIMIT  = 40;

   // first command code past the defined set
   localparam logic [CMD_W-1:0] CMD_UNDEF_FIRST = CMD_CONSUME + 3'd1;

   typedef struct packed {
      logic                status;
      logic [OB-1:0]       first_offset;
      logic [AMOUNT_W-1:0] first_length;
      logic [OB-1:0]       second_offset;
      logic [AMOUNT_W-1:0] second_length;
   } span_result_type;

   // region tracker and queue of expected response words
   class span_scoreboard;
      logic [SIZE_W-1:0] size_reg;
      longint unsigned   lo [2];
      longint unsigned   hi [2];
      bit                rd_sel;
      bit                wr_sel;
      longint unsigned   held;
      span_result_type   expected_q [$];
      int                errors;
      int                words_seen;

      function new();
         size_reg   = SIZE_RESET;
         lo         = '{0, 0};
         hi         = '{0, 0};
         rd_sel     = 1'b0;
         wr_sel     = 1'b0;
         held       = 0;
         errors     = 0;
         words_seen = 0;
      endfunction

      function void set_size(logic [SIZE_W-1:0] value);
         size_reg = value;
      endfunction

      // size saturates at the offset range
      function longint unsigned usable_bytes();
         longint unsigned cap;
         cap = longint'(1) << OB;
         return (size_reg > cap) ? cap : longint'(size_reg);
      endfunction

      function longint unsigned span_len(bit r);
         return (hi[r] > lo[r]) ? hi[r] - lo[r] : 0;
      endfunction

      function void empty_span(bit r);
         lo[r] = 0;
         hi[r] = 0;
      endfunction

      function span_result_type granted(longint unsigned o1, longint unsigned l1,
                                        longint unsigned o2, longint unsigned l2);
         span_result_type r;
         r.status        = STATUS_OK;
         r.first_offset  = OB'(o1);
         r.first_length  = AMOUNT_W'(l1);
         r.second_offset = OB'(o2);
         r.second_length = AMOUNT_W'(l2);
         return r;
      endfunction

      // advance the tracked state by one request word, queue its response
      function void note_request(logic [CMD_W-1:0] cmd, logic [AMOUNT_W-1:0] amt);
         span_result_type r;
         longint unsigned a;
         longint unsigned lr;
         longint unsigned rest;
         bit              rd;
         bit              wr;
         bit              other;
         r        = '0;
         r.status = STATUS_REFUSED;
         a        = amt;
         rd       = rd_sel;
         wr       = wr_sel;
         other    = !rd;
         case (cmd) inside
            CMD_CLEAR: begin
               // selectors are kept
               empty_span(1'b0);
               empty_span(1'b1);
               held     = 0;
               r.status = STATUS_OK;
            end
            CMD_RESERVE: begin
               if (rd == wr) begin
                  if (hi[wr] + a <= usable_bytes()) begin
                     held = a;
                     r    = granted(hi[wr], a, 0, 0);
                  end else if (lo[rd] >= a) begin
                     // wrap: write side moves to the other region at 0
                     wr_sel = !wr;
                     empty_span(!wr);
                     held = a;
                     r    = granted(0, a, 0, 0);
                  end
               end else if (hi[wr] + a <= lo[rd]) begin
                  held = a;
                  r    = granted(hi[wr], a, 0, 0);
               end
            end
            CMD_COMMIT: begin
               if (a <= held) begin
                  r       = granted(hi[wr], a, 0, 0);
                  hi[wr] += a;
                  held    = 0;
               end
            end
            CMD_PEEK, CMD_CONSUME: begin
               lr = span_len(rd);
               if (a <= lr) begin
                  r = granted(lo[rd], a, 0, 0);
                  if (cmd == CMD_CONSUME) begin
                     lo[rd] += a;
                     if (lo[rd] == hi[rd]) empty_span(rd);
                  end
               end else if (rd != wr && a <= lr + span_len(wr)) begin
                  // read spills into the write region
                  rest = a - lr;
                  r    = granted(lo[rd], lr, lo[other], rest);
                  if (cmd == CMD_CONSUME) begin
                     empty_span(rd);
                     rd_sel     = other;
                     lo[other] += rest;
                     if (lo[other] == hi[other]) empty_span(other);
                  end
               end
            end
            default: ;
         endcase
         expected_q.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= PRINT_LIMIT) $display("%0t mismatch: %s", $time, msg);
      endtask

      task check_response(span_result_type got);
         span_result_type want;
         words_seen++;
         if (expected_q.size() == 0) begin
            report($sformatf("response word %0d with nothing expected", words_seen));
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status)
            report($sformatf("word %0d status %0d, want %0d",
                             words_seen, got.status, want.status));
         if (got.first_offset !== want.first_offset)
            report($sformatf("word %0d first_offset %0d, want %0d",
                             words_seen, got.first_offset, want.first_offset));
         if (got.first_length !== want.first_length)
            report($sformatf("word %0d first_length %0d, want %0d",
                             words_seen, got.first_length, want.first_length));
         if (got.second_offset !== want.second_offset)
            report($sformatf("word %0d second_offset %0d, want %0d",
                             words_seen, got.second_offset, want.second_offset));
         if (got.second_length !== want.second_length)
            report($sformatf("word %0d second_length %0d, want %0d",
                             words_seen, got.second_length, want.second_length));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [SIZE_W-1:0] csr_wr_data;
   bit                idling;
   int                stuck_cycles = 0;
   span_scoreboard    board;

   bbrm_req_if                       req_chan ();
   bbrm_rsp_if #(.OFFSET_BITS(OB))   rsp_chan ();

   bip_buffer_region_manager_core #(
      .OFFSET_BITS(OB)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // response side stalls in random bursts while idling is set
   initial begin : rsp_stall
      int hold;
      hold = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0 && idling && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 7);
         rsp_chan.ready <= (hold == 0);
         if (hold > 0) hold--;
      end
   end

   // sample response words
   always @(posedge clock) begin
      span_result_type got;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         got.status        = rsp_chan.status;
         got.first_offset  = rsp_chan.first_offset;
         got.first_length  = rsp_chan.first_length;
         got.second_offset = rsp_chan.second_offset;
         got.second_length = rsp_chan.second_length;
         board.check_response(got);
      end
   end

   // watchdog: too long without any word moving
   always @(posedge clock) begin
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb_bip_buffer_region_manager_core failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // present one request word, return at the edge that takes it
   task automatic send_word(logic [CMD_W-1:0] cmd, logic [AMOUNT_W-1:0] amt);
      if (idling && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.command <= cmd;
      req_chan.amount  <= amt;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      board.note_request(cmd, amt);
   endtask

   // random word, amount picked around what the tracked state allows
   task automatic random_word();
      int                  pick;
      logic [CMD_W-1:0]    cmd;
      logic [AMOUNT_W-1:0] amt;
      longint              hint;
      longint              lr;
      longint              total;
      bit                  rd;
      bit                  wr;
      rd    = board.rd_sel;
      wr    = board.wr_sel;
      lr    = board.span_len(rd);
      total = lr + ((rd != wr) ? board.span_len(wr) : 0);
      pick  = $urandom_range(0, 99);
      if (pick < 30) begin
         cmd = CMD_RESERVE;
         if (rd == wr) begin
            hint = longint'(board.usable_bytes()) - longint'(board.hi[wr]);
            if (longint'(board.lo[rd]) > hint) hint = board.lo[rd];
         end else begin
            hint = longint'(board.lo[rd]) - longint'(board.hi[wr]);
         end
      end else if (pick < 55) begin
         cmd  = CMD_COMMIT;
         hint = board.held;
      end else if (pick < 70) begin
         cmd  = CMD_PEEK;
         hint = $urandom_range(0, 1) ? lr : total;
      end else if (pick < 92) begin
         cmd  = CMD_CONSUME;
         hint = $urandom_range(0, 1) ? lr : total;
      end else begin
         cmd  = CMD_CLEAR;
         hint = 0;
      end
      if (hint < 0) hint = 0;
      case ($urandom_range(0, 9))
         7:       amt = AMOUNT_W'(hint + 1);
         8:       amt = AMOUNT_W'(hint);
         9:       amt = AMOUNT_W'($urandom);
         default: amt = AMOUNT_W'($urandom_range(0, 32'(hint)));
      endcase
      // some noise: unknown codes and fully random words
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         cmd = 3'($urandom_range(CMD_UNDEF_FIRST, (1 << CMD_W) - 1));
      end else if (pick < 6) begin
         cmd = 3'($urandom_range(0, (1 << CMD_W) - 1));
         amt = AMOUNT_W'($urandom);
      end
      send_word(cmd, amt);
   endtask

   // drop valid and let every expected response come back
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      while (board.expected_q.size() != 0) @(posedge clock);
   endtask

   // buffer_size write while the block is idle
   task automatic write_size(logic [SIZE_W-1:0] value);
      wait_for_drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      board.set_size(value);
      csr_wr_en   <= 1'b0;
   endtask

   // main sequence
   initial begin
      logic [SIZE_W-1:0] size_plan [PHASES];
      int                sent;
      board            = new();
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      req_chan.valid   = 1'b0;
      req_chan.command = CMD_CLEAR;
      req_chan.amount  = '0;
      idling           = 1'b1;
      sent             = 0;
      size_plan = '{SIZE_RESET, 17'd16, 17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd300,
                    17'($urandom_range(1, 65536))};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed opener at the reset size
      send_word(CMD_PEEK, 17'd0);           // empty read of zero bytes
      send_word(CMD_CONSUME, 17'd1);        // nothing to read
      send_word(CMD_COMMIT, 17'd1);         // no reservation
      send_word(CMD_RESERVE, 17'h1FFFF);
      send_word(CMD_RESERVE, 17'd65536);
      send_word(CMD_RESERVE, 17'd4096);     // whole buffer
      send_word(CMD_RESERVE, 17'd3000);     // replaces the pending one
      send_word(CMD_COMMIT, 17'd3001);      // beyond reservation
      send_word(CMD_COMMIT, 17'd3000);
      send_word(CMD_PEEK, 17'd3000);
      send_word(CMD_CONSUME, 17'd2000);
      send_word(CMD_RESERVE, 17'd1500);     // switches writing to region b
      send_word(CMD_COMMIT, 17'd1500);
      send_word(CMD_PEEK, 17'd1200);        // spans both regions
      send_word(CMD_RESERVE, 17'd600);      // runs into the read start
      send_word(CMD_RESERVE, 17'd500);
      send_word(CMD_COMMIT, 17'd500);
      send_word(CMD_CONSUME, 17'd1200);     // cross-region consume
      send_word(CMD_CONSUME, 17'd1800);     // empties the read region
      for (int k = 0; k < 3; k++) send_word(CMD_UNDEF_FIRST + 3'(k), 17'h1FFFF);
      send_word(CMD_RESERVE, 17'd10);
      send_word(CMD_CLEAR, 17'h1FFFF);
      send_word(CMD_COMMIT, 17'd10);        // reservation dropped by clear

      // random streams, one per buffer size, regions kept across size changes
      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) write_size(size_plan[p]);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (sent >= PHASES * PHASE_WORDS - CALM_WORDS) idling = 1'b0;
            else if (sent % 40 == 0) idling = ($urandom_range(0, 3) != 0);
            random_word();
            sent++;
         end
      end

      wait_for_drain();
      repeat (4) @(posedge clock);
      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("tb_bip_buffer_region_manager_core passed");
      end else begin
         $display("tb_bip_buffer_region_manager_core failed");
      end
      $finish;
   end

endmodule
